### src/arfm_pkg.sv
// Package for the auto-range frequency meter.
// Item structs, command and register codes, controller states. No dependencies.
package arfm_pkg;

    typedef enum logic [1:0] {
        CMD_EDGE    = 2'd0,
        CMD_GATE    = 2'd1,
        CMD_SERVICE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_RATE      = 2'd0;
    localparam logic [1:0] REG_TO_GATE   = 2'd1;
    localparam logic [1:0] REG_TO_PERIOD = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    localparam logic [63:0] NS_PER_S = 64'd1000000000;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] edge_time;
        logic [31:0] gate_count_hz;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [31:0] frequency_out_hz;
        logic [63:0] period_out_ns;
        logic        result_valid;
        logic        gate_mode;
        logic        capture_on;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_FREQ,
        ST_WAIT_FREQ,
        ST_DIV_WHOLE,
        ST_WAIT_WHOLE,
        ST_DIV_FRAC,
        ST_WAIT_FRAC,
        ST_EDGE_DONE,
        ST_SERVICE,
        ST_DIV_GNS,
        ST_WAIT_GNS,
        ST_OUT
    } state_t;

    // divider operand select
    typedef enum logic [1:0] {
        DV_FREQ,
        DV_WHOLE,
        DV_FRAC,
        DV_GNS
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_freq;
        logic     cap_whole;
        logic     cap_frac;
        logic     edge_apply;
        logic     edge_first;
        logic     gate_apply;
        logic     service_apply;
        logic     gns_apply;
        logic     out_load;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic capture_en;
        logic have_prev;
        logic ticks_zero;
        logic div_done;
        logic gns_needed;
    } sts_t;

endpackage

### src/arfm_divider.sv
// Radix-2 restoring divider, 64-bit quotient, one bit a cycle.
// Depends on nothing; divisor zero gives all ones.
module arfm_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[63:0], q_reg[63]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[63:0];
endmodule

### src/arfm_datapath.sv
// Datapath: configuration, measurement state, divider and result register.
// Depends on arfm_pkg and arfm_divider.
module arfm_datapath
    import arfm_pkg::*;
#(
    parameter int TIMESTAMP_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  in_item_t    in_item,
    input  ctl_t        ctl,
    output sts_t        sts,
    output out_item_t   out_item
);
    localparam logic [63:0] TS_MASK = {64{1'b1}} >> (64 - TIMESTAMP_BITS);
    localparam logic [63:0] WHOLE_MAX = 64'd18446744073;

    logic [31:0] rate_reg, to_gate_reg, to_period_reg, timeout_reg;
    in_item_t    in_reg;
    logic [63:0] prev_reg, ticks_reg;
    logic        have_prev_reg;
    logic [31:0] edge_freq_reg;
    logic [63:0] edge_ns_reg;
    logic        edge_ok_reg, gate_req_reg;
    logic [31:0] last_ms_reg;
    logic        method_reg;
    logic [31:0] gate_freq_reg;
    logic        gate_ok_reg;
    logic [31:0] shown_f_reg;
    logic [63:0] shown_ns_reg;
    logic        cap_reg;
    logic [31:0] new_f_reg;
    logic [63:0] whole_reg, frac_reg, rest_reg;
    logic        whole_sat_reg;
    out_item_t   out_reg;

    logic [63:0] rate64, stamp, ticks, div_a, div_b, quo, rem;
    logic        div_done;
    logic [61:0] frac_prod;
    logic [64:0] whole_prod;
    logic        whole_big;
    logic [64:0] sum;
    logic [63:0] ns_val;

    assign rate64 = (rate_reg == 32'd0) ? 64'd1 : {32'd0, rate_reg};
    assign stamp  = in_reg.edge_time & TS_MASK;
    assign ticks  = (stamp - prev_reg) & TS_MASK;

    assign frac_prod = rest_reg[31:0] * NS_PER_S[29:0];

    always_comb begin
        unique case (ctl.div_sel)
            DV_FREQ:  begin div_a = rate64 + (ticks_reg >> 1); div_b = ticks_reg; end
            DV_WHOLE: begin div_a = ticks_reg; div_b = rate64; end
            DV_FRAC:  begin
                div_a = {2'b00, frac_prod} + (rate64 >> 1);
                div_b = rate64;
            end
            default:  begin
                div_a = NS_PER_S + {33'd0, shown_f_reg[31:1]};
                div_b = {32'd0, shown_f_reg};
            end
        endcase
    end

    arfm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(ctl.div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done),
        .quotient(quo), .remainder(rem)
    );

    assign whole_big  = (whole_reg > WHOLE_MAX);
    assign whole_prod = whole_reg[34:0] * NS_PER_S[29:0];
    assign sum        = {1'b0, whole_prod[63:0]} + {1'b0, frac_reg};
    assign ns_val     = (whole_sat_reg || whole_big || sum[64])
                        ? {64{1'b1}} : sum[63:0];

    always_ff @(posedge aclk) begin
        if (ctl.load_in) in_reg <= in_item;
        if (ctl.edge_first) ticks_reg <= ticks;
        if (ctl.cap_freq) new_f_reg <= quo[31:0];
        if (ctl.cap_whole) begin
            whole_reg     <= quo;
            rest_reg      <= rem;
            whole_sat_reg <= 1'b0;
        end
        if (ctl.cap_frac) frac_reg <= quo;
        if (ctl.out_load) begin
            out_reg.frequency_out_hz <= shown_f_reg;
            out_reg.period_out_ns    <= shown_ns_reg;
            out_reg.result_valid     <= method_reg ? gate_ok_reg
                                                   : (edge_ok_reg | gate_ok_reg);
            out_reg.gate_mode        <= method_reg;
            out_reg.capture_on       <= cap_reg;
        end
        if (!aresetn) begin
            rate_reg <= 32'd72000000; to_gate_reg <= 32'd7200;
            to_period_reg <= 32'd7000; timeout_reg <= 32'd1500;
            prev_reg <= '0; have_prev_reg <= 1'b0; edge_freq_reg <= '0;
            edge_ns_reg <= '0; edge_ok_reg <= 1'b0; gate_req_reg <= 1'b0;
            last_ms_reg <= '0; method_reg <= 1'b0; gate_freq_reg <= '0;
            gate_ok_reg <= 1'b0; shown_f_reg <= '0; shown_ns_reg <= '0;
            cap_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_RATE:      rate_reg      <= cfg_data;
                    REG_TO_GATE:   to_gate_reg   <= cfg_data;
                    REG_TO_PERIOD: to_period_reg <= cfg_data;
                    default:       timeout_reg   <= cfg_data;
                endcase
            end
            if (ctl.edge_first) begin
                last_ms_reg <= in_reg.now_ms;
                prev_reg    <= stamp;
                have_prev_reg <= 1'b1;
            end
            if (ctl.edge_apply) begin
                edge_freq_reg <= new_f_reg;
                edge_ns_reg   <= ns_val;
                edge_ok_reg   <= 1'b1;
                if (ticks_reg <= {32'd0, to_gate_reg}) begin
                    gate_req_reg <= 1'b1;
                    cap_reg      <= 1'b0;
                end
            end
            if (ctl.gate_apply) begin
                gate_freq_reg <= in_reg.gate_count_hz;
                gate_ok_reg   <= 1'b1;
                if (method_reg) begin
                    shown_f_reg <= in_reg.gate_count_hz;
                    if (in_reg.gate_count_hz <= to_period_reg) begin
                        method_reg <= 1'b0; edge_ok_reg <= 1'b0;
                        gate_req_reg <= 1'b0; have_prev_reg <= 1'b0;
                        edge_ns_reg <= '0; prev_reg <= '0; cap_reg <= 1'b1;
                    end
                end
            end
            if (ctl.service_apply) begin : svc
                logic        m, eok, greq, hp;
                logic [31:0] ef, sf;
                logic [63:0] en, sn, pv;
                m = method_reg; eok = edge_ok_reg; greq = gate_req_reg;
                hp = have_prev_reg; ef = edge_freq_reg; en = edge_ns_reg;
                pv = prev_reg; sf = shown_f_reg; sn = shown_ns_reg;
                if (!m && eok && (in_reg.now_ms - last_ms_reg) > timeout_reg) begin
                    eok = 1'b0; ef = '0; en = '0; pv = '0; hp = 1'b0; greq = 1'b0;
                end
                if (!m && greq) begin
                    sf = ef; m = 1'b1; greq = 1'b0; eok = 1'b0; hp = 1'b0;
                end
                if (!m) begin
                    if (eok) begin sf = ef; sn = en; end
                    else if (gate_ok_reg) sf = gate_freq_reg;
                    else begin sf = '0; sn = '0; end
                end else if (gate_ok_reg) sf = gate_freq_reg;
                method_reg <= m; edge_ok_reg <= eok; gate_req_reg <= greq;
                have_prev_reg <= hp; edge_freq_reg <= ef; edge_ns_reg <= en;
                prev_reg <= pv; shown_f_reg <= sf; shown_ns_reg <= sn;
            end
            if (ctl.gns_apply) shown_ns_reg <= quo;
        end
    end

    assign sts.cmd        = cmd_t'(in_reg.command);
    assign sts.capture_en = cap_reg;
    assign sts.have_prev  = have_prev_reg;
    assign sts.ticks_zero = (ticks == 64'd0);
    assign sts.div_done   = div_done;
    assign sts.gns_needed = method_reg && (shown_f_reg != 32'd0);
    assign out_item       = out_reg;
endmodule

### src/arfm_controller.sv
// Controller state machine: sequences each item through the datapath.
// Depends on arfm_pkg.
module arfm_controller
    import arfm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output ctl_t ctl
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                unique case (sts.cmd)
                    CMD_EDGE: begin
                        if (!sts.capture_en) state_next = ST_OUT;
                        else if (!sts.have_prev || sts.ticks_zero) state_next = ST_OUT;
                        else state_next = ST_DIV_FREQ;
                    end
                    CMD_GATE:    state_next = ST_OUT;
                    CMD_SERVICE: state_next = ST_SERVICE;
                    default:     state_next = ST_OUT;
                endcase
            end
            ST_DIV_FREQ:   state_next = ST_WAIT_FREQ;
            ST_WAIT_FREQ:  if (sts.div_done) state_next = ST_DIV_WHOLE;
            ST_DIV_WHOLE:  state_next = ST_WAIT_WHOLE;
            ST_WAIT_WHOLE: if (sts.div_done) state_next = ST_DIV_FRAC;
            ST_DIV_FRAC:   state_next = ST_WAIT_FRAC;
            ST_WAIT_FRAC:  if (sts.div_done) state_next = ST_EDGE_DONE;
            ST_EDGE_DONE:  state_next = ST_OUT;
            ST_SERVICE:    state_next = ST_DIV_GNS;
            ST_DIV_GNS:    state_next = sts.gns_needed ? ST_WAIT_GNS : ST_OUT;
            ST_WAIT_GNS:   if (sts.div_done) state_next = ST_OUT;
            ST_OUT:        if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.div_sel = DV_FREQ;
        unique case (state_reg)
            ST_IDLE:   ctl.load_in = in_valid;
            ST_DECODE: begin
                ctl.edge_first = (sts.cmd == CMD_EDGE) && sts.capture_en;
                ctl.gate_apply = (sts.cmd == CMD_GATE);
            end
            ST_DIV_FREQ:   begin ctl.div_sel = DV_FREQ; ctl.div_start = 1'b1; end
            ST_WAIT_FREQ:  ctl.cap_freq = sts.div_done;
            ST_DIV_WHOLE:  begin ctl.div_sel = DV_WHOLE; ctl.div_start = 1'b1; end
            ST_WAIT_WHOLE: ctl.cap_whole = sts.div_done;
            ST_DIV_FRAC:   begin ctl.div_sel = DV_FRAC; ctl.div_start = 1'b1; end
            ST_WAIT_FRAC:  begin ctl.div_sel = DV_FRAC; ctl.cap_frac = sts.div_done; end
            ST_EDGE_DONE:  ctl.edge_apply = 1'b1;
            ST_SERVICE:    ctl.service_apply = 1'b1;
            ST_DIV_GNS:    begin ctl.div_sel = DV_GNS; ctl.div_start = sts.gns_needed; end
            ST_WAIT_GNS:   begin ctl.div_sel = DV_GNS; ctl.gns_apply = sts.div_done; end
            ST_OUT:        ctl.out_load = !ov_reg || out_ready;
            default:       ctl = '0;
        endcase
    end

    always_comb begin
        ov_next = ov_reg;
        if (out_ready) ov_next = 1'b0;
        if (ctl.out_load) ov_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
endmodule

### src/auto_range_frequency_meter.sv
// Auto-range frequency meter top level: controller plus datapath.
// Depends on arfm_pkg, arfm_controller, arfm_datapath.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    in_item_t
//   m_       out        m_valid / m_ready    out_item_t
//   cfg_     in         cfg_we               cfg_index, cfg_data
//
// One item at a time. Edge items that measure take three passes of the shared
// bit-serial divider; service items in gate mode take one pass when the shown
// frequency is nonzero; others take none. The result register frees the next
// item while a result waits. Reset is synchronous and restores register defaults.
module auto_range_frequency_meter
    import arfm_pkg::*;
#(
    parameter int TIMESTAMP_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    ctl_t ctl;
    sts_t sts;

    arfm_controller u_ctl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .sts(sts), .ctl(ctl)
    );

    arfm_datapath #(.TIMESTAMP_BITS(TIMESTAMP_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_item(s_item), .ctl(ctl), .sts(sts), .out_item(m_item)
    );

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_start |-> !s_ready) else $error("divider started while idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result dropped");
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.edge_apply, ctl.gate_apply, ctl.service_apply, ctl.gns_apply}))
        else $error("conflicting updates");
endmodule
